// File: rtl/slist_pkg.sv
`timescale 1ns / 1ps

package slist_pkg;

    // Default capacity of the list
    localparam int DEPTH_DEFAULT = 16;

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic       ok;
        logic [3:0] position;
        logic [4:0] count;
    } t_rsp;

    // Update strobes broadcast to every cell: compare in the compare cycle, insert and remove in the apply cycle
    typedef struct packed {
        logic cmp;
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

// File: rtl/slist_cell.sv
`timescale 1ns / 1ps

module slist_cell
    import slist_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic               i_occupied,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_prev_entry,
    input  logic signed [31:0] i_next_entry,
    input  logic               i_prev_le,
    input  logic               i_prev_lt,
    output logic signed [31:0] o_entry,
    output logic               o_le,
    output logic               o_lt,
    output logic               o_ins_hot,
    output logic               o_match
);

    logic signed [31:0] r_entry;
    logic signed [31:0] n_entry;
    logic               r_le;
    logic               r_lt;

    // Compare stage: an empty cell counts as greater than any value
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp) begin
            r_le <= i_occupied && (r_entry <= i_value);
            r_lt <= i_occupied && (r_entry <  i_value);
        end
    end

    // Shift stage: take from the left on insert, from the right on remove
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins && !r_le) begin
            n_entry = i_prev_le ? i_value : i_prev_entry;
        end else if (i_ctrl.rem && !r_lt) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry   = r_entry;
    assign o_le      = r_le;
    assign o_lt      = r_lt;
    assign o_ins_hot = !r_le && i_prev_le;
    assign o_match   = r_le && !r_lt && i_prev_lt;

endmodule

// File: rtl/sorted_list_insert_remove_top.sv
`timescale 1ns / 1ps

// Sorted list of signed 32-bit values, kept in ascending order in a row of
// DEPTH cells. Each request carries an opcode (insert, remove first match,
// find first match) and a value; each request yields exactly one response
// with a success flag, the index concerned and the entry count afterwards.
// Both channels use valid/ready; a transfer happens when both are high.
// A request is registered, then a compare cycle in every cell and an
// apply cycle that shifts the row and loads the output register yield its
// response. The compare-then-shift sequence over the cell row sets the
// pace: the next request is taken in the apply cycle of the current one.
// Stall: the response sits in an output register; while the receiver holds
// ready low and that register is full, the apply cycle waits and the list
// is left untouched. Reset clears the entry count and the control state;
// the cell contents are undefined until written and are never read beyond
// the count.
module sorted_list_insert_remove_top
    import slist_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state r_state, n_state;
    t_req   r_req;
    logic [CNT_W-1:0] r_count, n_count;
    logic   r_out_valid;
    t_rsp   r_out_data, n_out_data;

    logic in_fire, commit, full, found;
    logic [IDX_W-1:0] ins_pos, rem_pos;
    t_cell_ctrl ctrl;

    logic signed [31:0] cell_entry [DEPTH];
    logic [DEPTH-1:0] cell_le, cell_lt, cell_ins_hot, cell_match;

    // Free to take a request when idle, or when the current one commits
    assign commit     = (r_state == S_APPLY) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE) || commit;
    assign in_fire    = i_in_valid && o_in_ready;
    assign full       = (r_count == CNT_W'(DEPTH));

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_fire) n_state = S_CMP;
            S_CMP:   n_state = S_APPLY;
            S_APPLY: begin
                if (in_fire) begin
                    n_state = S_CMP;
                end else if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the request for the compare and apply cycles
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req <= i_in_data;
        end
    end

    // Cell row: each cell talks only to its neighbours
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] prev_entry, next_entry;
        logic               prev_le, prev_lt;

        if (g == 0) begin : g_first
            assign prev_entry = cell_entry[g];
            assign prev_le    = 1'b1;
            assign prev_lt    = 1'b1;
        end else begin : g_inner
            assign prev_entry = cell_entry[g-1];
            assign prev_le    = cell_le[g-1];
            assign prev_lt    = cell_lt[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign next_entry = cell_entry[g];
        end else begin : g_body
            assign next_entry = cell_entry[g+1];
        end

        slist_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_occupied   (CNT_W'(g) < r_count),
            .i_value      (r_req.value),
            .i_prev_entry (prev_entry),
            .i_next_entry (next_entry),
            .i_prev_le    (prev_le),
            .i_prev_lt    (prev_lt),
            .o_entry      (cell_entry[g]),
            .o_le         (cell_le[g]),
            .o_lt         (cell_lt[g]),
            .o_ins_hot    (cell_ins_hot[g]),
            .o_match      (cell_match[g])
        );
    end

    // Encode the one-hot boundary flags into indices
    always_comb begin
        ins_pos = '0;
        rem_pos = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (cell_ins_hot[k]) ins_pos |= IDX_W'(k);
            if (cell_match[k])   rem_pos |= IDX_W'(k);
        end
    end

    assign found = |cell_match;

    // Cell strobes: shift only when the operation succeeds
    always_comb begin
        ctrl.cmp = (r_state == S_CMP);
        ctrl.ins = commit && (r_req.opcode == OP_INSERT) && !full;
        ctrl.rem = commit && (r_req.opcode == OP_REMOVE) && found;
    end

    // Response and next count
    always_comb begin
        n_count             = r_count;
        n_out_data.ok       = 1'b0;
        n_out_data.position = '0;
        case (r_req.opcode)
            OP_INSERT: begin
                if (!full) begin
                    n_count             = r_count + CNT_W'(1);
                    n_out_data.ok       = 1'b1;
                    n_out_data.position = 4'(ins_pos);
                end
            end
            OP_REMOVE: begin
                if (found) begin
                    n_count             = r_count - CNT_W'(1);
                    n_out_data.ok       = 1'b1;
                    n_out_data.position = 4'(rem_pos);
                end
            end
            OP_FIND: begin
                if (found) begin
                    n_out_data.ok       = 1'b1;
                    n_out_data.position = 4'(rem_pos);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_out_data.count = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (commit) begin
            r_count <= n_count;
        end
    end

    // Output register: load on commit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: rtl/slist_chk.sv
`timescale 1ns / 1ps

module slist_chk
    import slist_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_rsp o_out_data
);

    // A stalled response holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("response changed while stalled");

    // A failed step reports index zero
    a_fail_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.ok |-> o_out_data.position == 4'd0)
        else $error("failed step with non-zero position");

    // The count never exceeds the capacity (checked for DEPTH up to 16)
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (DEPTH > 16) || (int'(o_out_data.count) <= DEPTH))
        else $error("count beyond capacity");

    // No response straight after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid after reset");

    // Close the input for the compare cycle after a request is taken
    a_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken during the compare cycle");

endmodule

bind sorted_list_insert_remove_top slist_chk #(.DEPTH(DEPTH)) u_slist_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import slist_pkg::*;
();

    // Opcode 3 is not used by the block; it must answer with a failed no-op
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam int LIST_DEPTH  = DEPTH_DEFAULT;
    localparam int RAND_REQS   = 1700;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_PRINTS  = 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_req i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_rsp o_out_data;

    sorted_list_insert_remove_top #(.DEPTH(LIST_DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // Requests waiting to be offered, and responses the shadow list predicts
    t_req pending_reqs[$];
    t_rsp rsp_expected[$];

    // Shadow copy of the sorted list, advanced on every accepted request
    logic signed [31:0] shadow_vals[LIST_DEPTH];
    int shadow_len;

    int err_count;
    int n_accepted;
    int n_checked;
    int n_ins_ok, n_ins_full, n_rem_ok, n_rem_fail, n_find_hit, n_find_miss, n_nop;
    int peak_len;
    int cycle_cnt;
    logic calm;
    logic hold_rsp;

    initial begin
        err_count = 0;
        n_accepted = 0;
        n_checked = 0;
        n_ins_ok = 0;
        n_ins_full = 0;
        n_rem_ok = 0;
        n_rem_fail = 0;
        n_find_hit = 0;
        n_find_miss = 0;
        n_nop = 0;
        peak_len = 0;
        cycle_cnt = 0;
        calm = 1'b0;
        hold_rsp = 1'b0;
        shadow_len = 0;
    end

    // ------------------------------------------------------------------
    // Clock and a single reset pulse at the start of the run
    // ------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Shadow list: apply one request and return the response it must give
    // ------------------------------------------------------------------
    function automatic t_rsp apply_to_shadow(t_req req);
        t_rsp rsp;
        logic signed [31:0] v;
        int slot;
        v = req.value;
        rsp = '0;
        slot = shadow_len;
        case (req.opcode) inside
            OP_INSERT: begin
                if (shadow_len < LIST_DEPTH) begin
                    // Land before the first strictly greater entry, so
                    // duplicates keep their arrival order
                    for (int i = shadow_len - 1; i >= 0; i--) begin
                        if (shadow_vals[i] > v) slot = i;
                    end
                    for (int i = shadow_len; i > slot; i--) begin
                        shadow_vals[i] = shadow_vals[i - 1];
                    end
                    shadow_vals[slot] = v;
                    shadow_len++;
                    rsp.ok = 1'b1;
                    rsp.position = slot[3:0];
                    n_ins_ok++;
                end else begin
                    n_ins_full++;
                end
            end
            OP_REMOVE, OP_FIND: begin
                for (int i = shadow_len - 1; i >= 0; i--) begin
                    if (shadow_vals[i] == v) slot = i;
                end
                if (slot < shadow_len) begin
                    rsp.ok = 1'b1;
                    rsp.position = slot[3:0];
                    if (req.opcode == OP_REMOVE) begin
                        // Close the gap left by the removed entry
                        for (int i = slot; i + 1 < shadow_len; i++) begin
                            shadow_vals[i] = shadow_vals[i + 1];
                        end
                        shadow_len--;
                        n_rem_ok++;
                    end else begin
                        n_find_hit++;
                    end
                end else if (req.opcode == OP_REMOVE) begin
                    n_rem_fail++;
                end else begin
                    n_find_miss++;
                end
            end
            default: n_nop++;
        endcase
        rsp.count = shadow_len[4:0];
        if (shadow_len > peak_len) peak_len = shadow_len;
        return rsp;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (err_count < MAX_PRINTS) begin
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        end
        err_count++;
    endtask

    // Gap length for either side: mostly none or short, now and then long,
    // and none at all while the calm stretch is on
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Values mostly from a narrow band so that removes and finds hit and
    // duplicates pile up; the rest are extremes or fully random words
    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return $signed($urandom_range(0, 12)) - 6;
        if (r < 65) begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh8000_0001;
                2: return 32'sh7FFF_FFFE;
                default: return 32'sh7FFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    task automatic queue_req(logic [1:0] op, logic signed [31:0] v);
        t_req req;
        req.opcode = op;
        req.value = v;
        pending_reqs.push_back(req);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer pending requests, hold each until it is taken
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                rsp_expected.push_back(apply_to_shadow(i_in_data));
                n_accepted++;
            end
            // Advance only once the current request has gone (or none is up)
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_reqs.pop_front();
                    gap_left = pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each response against the oldest prediction, and
    // stall the response side at random
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_checked++;
                if (rsp_expected.size() == 0) begin
                    report_mismatch("response with no request waiting", 1, 0);
                end else begin
                    want = rsp_expected.pop_front();
                    if (o_out_data.ok !== want.ok)
                        report_mismatch("ok", o_out_data.ok, want.ok);
                    if (o_out_data.position !== want.position)
                        report_mismatch("position", o_out_data.position, want.position);
                    if (o_out_data.count !== want.count)
                        report_mismatch("count", o_out_data.count, want.count);
                end
            end
            if (hold_rsp) begin
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // Long hold-off on the response side while requests keep coming, so
    // the block backs up and drops its input ready
    initial begin
        wait (n_accepted >= 60);
        @(posedge i_clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rsp <= 1'b0;
    end

    // Cycle counter: toggle calm stretches and enforce the run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 400 == 0) calm <= ($urandom_range(0, 3) == 0);
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d responses still due",
                     cycle_cnt, rsp_expected.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int ins_bias;
        int r;
        logic [1:0] op;

        // Directed: empty-list failures, unused opcode, extremes, duplicates
        queue_req(OP_FIND, 32'sd0);
        queue_req(OP_REMOVE, 32'sd5);
        queue_req(OP_NOP, 32'shFFFF_FFFF);
        queue_req(OP_INSERT, 32'sh7FFF_FFFF);
        queue_req(OP_INSERT, 32'sh8000_0000);
        queue_req(OP_INSERT, 32'sd0);
        queue_req(OP_INSERT, 32'sd0);
        queue_req(OP_INSERT, -32'sd1);
        queue_req(OP_FIND, 32'sd0);
        queue_req(OP_FIND, 32'sd1);
        queue_req(OP_REMOVE, 32'sd1);
        queue_req(OP_REMOVE, 32'sd0);
        // Fill to capacity, then hit the full-list rejection
        for (int i = 0; i < LIST_DEPTH - 4; i++) queue_req(OP_INSERT, 32'(i % 5) - 2);
        queue_req(OP_INSERT, 32'sd3);
        queue_req(OP_NOP, 32'sd0);
        queue_req(OP_REMOVE, 32'sh7FFF_FFFF);

        // Random: phases that lean towards inserting or removing so the
        // list swings between empty and full
        ins_bias = 50;
        for (int n = 0; n < RAND_REQS; n++) begin
            if (n % 120 == 0) begin
                case ($urandom_range(0, 2))
                    0: ins_bias = 80;
                    1: ins_bias = 50;
                    default: ins_bias = 20;
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < ins_bias) op = OP_INSERT;
            else if (r < 97 && r % 2 == 0) op = OP_REMOVE;
            else if (r < 97) op = OP_FIND;
            else op = OP_NOP;
            queue_req(op, pick_value());
        end

        // Drain: wait for every request to go and every response to arrive
        do @(negedge i_clk);
        while (pending_reqs.size() > 0 || i_in_valid || rsp_expected.size() > 0);
        repeat (10) @(posedge i_clk);
        if (o_out_valid) report_mismatch("response after drain", 1, 0);

        $display("Ran %0d requests in %0d cycles: %0d inserts, %0d rejected as full, peak %0d",
                 n_accepted, cycle_cnt, n_ins_ok, n_ins_full, peak_len);
        $display("Removes %0d hit / %0d missed, finds %0d hit / %0d missed, %0d no-ops",
                 n_rem_ok, n_rem_fail, n_find_hit, n_find_miss, n_nop);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
